@@ src/cds_pixel_reassembly_defines.svh @@
// ----------------------------------------------------------------------------
// cds_pixel_reassembly_defines.svh
// Assertion macros for the CDS pixel reassembly block.
// ----------------------------------------------------------------------------
`ifndef CDS_PIXEL_REASSEMBLY_DEFINES_SVH
`define CDS_PIXEL_REASSEMBLY_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, idle during reset
`define CDSPR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, idle during reset
`define CDSPR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ src/cdspr_pkg.sv @@
// ----------------------------------------------------------------------------
// cdspr_pkg
// Shared types and constants of the CDS pixel reassembly block.
// ----------------------------------------------------------------------------
package cdspr_pkg;

    // Fixed camera geometry: four readout channels per quadrant, four quadrants
    localparam int CAM_CHANNELS = 4;
    localparam int QUADRANTS    = 4;

    // Field widths
    localparam int PIX_W   = 16;
    localparam int QUAD_W  = $clog2(QUADRANTS);
    localparam int FRAME_W = 12;
    localparam int ROW_W   = 9;
    localparam int COL_W   = 11;
    localparam int IROW_W  = 10;
    localparam int ICOL_W  = 11;
    localparam int CFGW_W  = 11;
    localparam int CFGH_W  = 10;
    localparam int TDATA_W = 56;

    // Register indexes
    localparam logic REG_DATA_WIDTH  = 1'b0;
    localparam logic REG_DATA_HEIGHT = 1'b1;

    // Register reset values
    localparam logic [CFGW_W-1:0] DATA_WIDTH_RST  = 11'd1024;
    localparam logic [CFGH_W-1:0] DATA_HEIGHT_RST = 10'd512;

    // Offset added before the reset level is taken away
    localparam logic [PIX_W-1:0] CDS_OFFSET = 16'd2048;

    // Camera channel slot per lane (col mod 4), lane 0 in the lowest bits
    localparam logic [3:0][1:0] ORDER_EVEN = {2'd0, 2'd1, 2'd3, 2'd2};
    localparam logic [3:0][1:0] ORDER_ODD  = {2'd3, 2'd2, 2'd0, 2'd1};

    // Frame store access request
    typedef struct packed {
        logic en;
        logic wr;
    } t_store_ctl;

endpackage

@@ src/cdspr_frame_store.sv @@
// ----------------------------------------------------------------------------
// cdspr_frame_store
// Single-port frame store for reset pixels, one access per cycle, read
// data registered.
// ----------------------------------------------------------------------------
module cdspr_frame_store #(
    parameter int DEPTH  = 524288,
    parameter int ADDR_W = 19
) (
    input  logic                      i_clk,
    input  cdspr_pkg::t_store_ctl     i_ctl,
    input  logic [ADDR_W-1:0]         i_addr,
    input  logic [cdspr_pkg::PIX_W-1:0] i_wdata,
    output logic [cdspr_pkg::PIX_W-1:0] o_rdata
);
    import cdspr_pkg::*;

    logic [PIX_W-1:0] r_mem [DEPTH];
    logic [PIX_W-1:0] r_rdata;

    // Write a reset pixel or read one back, hold read data otherwise
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            if (i_ctl.wr) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/cds_pixel_reassembly.sv @@
// An accepted item passes the stage 1, stage 2 and stage 3 registers on its way to the master side.
// Throughput: one item per cycle while the master side takes results; the rate is
// set by the single frame store port, which takes one read or one write each cycle.
// Reset pixels and ignored samples give no result and free their slot.
// Reset (synchronous, active low) clears the stage valid bits and sets
// data_width to 1024 and data_height to 512; the frame store is not cleared.
`include "cds_pixel_reassembly_defines.svh"
// ----------------------------------------------------------------------------
// cds_pixel_reassembly
// Correlated double sampling and full-image address mapping of raw quadrant
// pixels: three-stage pipeline (decode, store access, subtract).
// ----------------------------------------------------------------------------
module cds_pixel_reassembly #(
    parameter int MAX_WIDTH    = 1024,
    parameter int MAX_HEIGHT   = 512
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_addr,
    input  logic [cdspr_pkg::CFGW_W-1:0]    i_cfg_wdata,
    // Input items
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // raw_pixel[15:0], quadrant[17:16], frame_index[29:18], row[38:30],
    // col[49:39], zero fill[55:50]
    input  logic [cdspr_pkg::TDATA_W-1:0]   i_s_axis_tdata,
    // Result items
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // out_pixel[15:0], image_row[25:16], image_col[36:26], out_frame[48:37],
    // zero fill[55:49]
    output logic [cdspr_pkg::TDATA_W-1:0]   o_m_axis_tdata
);
    import cdspr_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TOP_W  = MAX_WIDTH - (MAX_WIDTH % CAM_CHANNELS);
    localparam int MULW_W = $clog2(MAX_WIDTH + 1);
    localparam int PROD_W = ROW_W + MULW_W + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFGW_W-1:0] r_data_width;
    logic [CFGH_W-1:0] r_data_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_width  <= DATA_WIDTH_RST;
            r_data_height <= DATA_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_DATA_WIDTH:  r_data_width  <= i_cfg_wdata;
                REG_DATA_HEIGHT: r_data_height <= i_cfg_wdata[CFGH_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective width and height after rounding and clamping
    logic [CFGW_W-1:0] w_eff;
    logic [CFGH_W-1:0] h_eff;

    always_comb begin
        w_eff = {r_data_width[CFGW_W-1:2], 2'b00};
        if (w_eff < CFGW_W'(CAM_CHANNELS)) begin
            w_eff = CFGW_W'(CAM_CHANNELS);
        end else if (int'(w_eff) > TOP_W) begin
            w_eff = CFGW_W'(TOP_W);
        end
        h_eff = r_data_height;
        if (h_eff == '0) begin
            h_eff = CFGH_W'(1);
        end else if (int'(h_eff) > MAX_HEIGHT) begin
            h_eff = CFGH_W'(MAX_HEIGHT);
        end
    end

    // ------------------------------------------------------------------
    // Stage handshake: each stage moves when it is empty or the next moves
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3;
    logic en1, en2, en3;

    assign en3 = !r_v3 || i_m_axis_tready;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_s_axis_tready = en1;

    // ------------------------------------------------------------------
    // Decode of the incoming item
    // ------------------------------------------------------------------
    logic [PIX_W-1:0]   in_pix;
    logic [QUAD_W-1:0]  in_quad;
    logic [FRAME_W-1:0] in_frame;
    logic [ROW_W-1:0]   in_row;
    logic [COL_W-1:0]   in_col;

    assign in_pix   = i_s_axis_tdata[15:0];
    assign in_quad  = i_s_axis_tdata[17:16];
    assign in_frame = i_s_axis_tdata[29:18];
    assign in_row   = i_s_axis_tdata[38:30];
    assign in_col   = i_s_axis_tdata[49:39];

    logic              in_keep;
    logic              in_is_reset;
    logic [COL_W-1:0]  in_store_col;
    logic [PROD_W-1:0] in_row_base;
    logic [ADDR_W-1:0] in_addr;
    logic [IROW_W:0]   in_flip_row;
    logic [IROW_W-1:0] in_irow;
    logic [1:0]        in_slot;
    logic [8:0]        in_quarter;
    logic [ICOL_W-1:0] in_slot_off;
    logic [ICOL_W-1:0] in_icol;

    always_comb begin
        // Classify: ignored, reset pixel or data pixel
        in_keep     = (CFGH_W'(in_row) < h_eff) &&
                      ((COL_W + 1)'(in_col) < {w_eff, 1'b0});
        in_is_reset = (in_col >= w_eff);

        // Store address: row times the store pitch plus the column
        in_store_col = in_is_reset ? (in_col - w_eff) : in_col;
        in_row_base  = PROD_W'(in_row) * PROD_W'(MAX_WIDTH);
        in_addr      = ADDR_W'(in_row_base + PROD_W'(in_store_col));

        // Image row: flip odd quadrants below the upper half
        in_flip_row = {h_eff, 1'b0} - (IROW_W + 1)'(1) - (IROW_W + 1)'(in_row);
        in_irow     = in_quad[0] ? in_flip_row[IROW_W-1:0] : IROW_W'(in_row);

        // Image column: deinterleave camera channels, place the quadrant
        in_slot    = in_quad[0] ? ORDER_ODD[in_col[1:0]] : ORDER_EVEN[in_col[1:0]];
        in_quarter = w_eff[CFGW_W-1:2];
        case (in_slot)
            2'd0:    in_slot_off = '0;
            2'd1:    in_slot_off = ICOL_W'(in_quarter);
            2'd2:    in_slot_off = ICOL_W'({in_quarter, 1'b0});
            default: in_slot_off = ICOL_W'(in_quarter) + ICOL_W'({in_quarter, 1'b0});
        endcase
        in_icol = (in_quad[1] ? ICOL_W'(w_eff) : ICOL_W'(0)) +
                  ICOL_W'(in_col[COL_W-1:2]) + in_slot_off;
    end

    // ------------------------------------------------------------------
    // Stage 1: decoded item
    // ------------------------------------------------------------------
    logic              r_wr1;
    logic [ADDR_W-1:0] r_addr1;
    logic [PIX_W-1:0]  r_pix1;
    logic [FRAME_W-1:0] r_frame1;
    logic [IROW_W-1:0] r_irow1;
    logic [ICOL_W-1:0] r_icol1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= i_s_axis_tvalid && in_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_wr1    <= in_is_reset;
            r_addr1  <= in_addr;
            r_pix1   <= in_pix;
            r_frame1 <= in_frame;
            r_irow1  <= in_irow;
            r_icol1  <= in_icol;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: frame store access; reset pixels end here
    // ------------------------------------------------------------------
    t_store_ctl        store_ctl;
    logic [PIX_W-1:0]  store_rdata;

    assign store_ctl.en = en2 && r_v1;
    assign store_ctl.wr = r_wr1;

    cdspr_frame_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_ctl   (store_ctl),
        .i_addr  (r_addr1),
        .i_wdata (r_pix1),
        .o_rdata (store_rdata)
    );

    logic [PIX_W-1:0]   r_pix2;
    logic [FRAME_W-1:0] r_frame2;
    logic [IROW_W-1:0]  r_irow2;
    logic [ICOL_W-1:0]  r_icol2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1 && !r_wr1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_pix2   <= r_pix1;
            r_frame2 <= r_frame1;
            r_irow2  <= r_irow1;
            r_icol2  <= r_icol1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: add the offset and subtract the previous frame's reset level (frame 0 passes raw), output register
    // ------------------------------------------------------------------
    logic [PIX_W-1:0]   n_pix3;
    logic [PIX_W-1:0]   r_pix3;
    logic [FRAME_W-1:0] r_frame3;
    logic [IROW_W-1:0]  r_irow3;
    logic [ICOL_W-1:0]  r_icol3;

    assign n_pix3 = (r_frame2 == '0) ? r_pix2 : (r_pix2 + CDS_OFFSET - store_rdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_pix3   <= n_pix3;
            r_frame3 <= r_frame2;
            r_irow3  <= r_irow2;
            r_icol3  <= r_icol2;
        end
    end

    assign o_m_axis_tvalid = r_v3;
    assign o_m_axis_tdata  = {7'd0, r_frame3, r_icol3, r_irow3, r_pix3};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `CDSPR_ASSERT_NOW(a_full_when_blocked, !o_s_axis_tready,
        r_v1 && r_v2 && r_v3 && !i_m_axis_tready, "input blocked with a free stage")
    `CDSPR_ASSERT_NEXT(a_stage2_holds, r_v2 && !en3,
        r_v2 && $stable(r_pix2) && $stable(r_icol2), "stage 2 item lost while stalled")
    `CDSPR_ASSERT_NEXT(a_first_frame_pass, r_v2 && en3 && (r_frame2 == '0),
        o_m_axis_tdata[15:0] == $past(r_pix2), "first frame pixel altered")

endmodule

@@ bench/cdspr_checker.sv @@
// ----------------------------------------------------------------------------
// cdspr_checker
// Watches the register port and both item streams of the CDS pixel
// reassembly block. Keeps its own copy of the registers and the reset-level
// store, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module cdspr_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_addr,
    input  logic [cdspr_pkg::CFGW_W-1:0]    i_cfg_wdata,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    // raw_pixel, quadrant, frame_index, row, col, zero fill
    input  logic [cdspr_pkg::TDATA_W-1:0]   i_in_data,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    // out_pixel, image_row, image_col, out_frame, zero fill
    input  logic [cdspr_pkg::TDATA_W-1:0]   i_out_data,
    output int                              o_pending,
    output int                              o_errors,
    output int                              o_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import cdspr_pkg::*;

    localparam int unsigned LINE_PITCH = 1024;
    localparam int unsigned WIDTH_CAP  = 1024;
    localparam int unsigned HEIGHT_CAP = 512;
    localparam logic [15:0] BLACK_LIFT = 16'd2048;

    typedef struct packed {
        logic [15:0] pix;
        logic [9:0]  row;
        logic [10:0] col;
        logic [11:0] frame;
    } t_pixel_result;

    logic [CFGW_W-1:0] cfg_width  = DATA_WIDTH_RST;
    logic [CFGH_W-1:0] cfg_height = DATA_HEIGHT_RST;
    logic [15:0]       reset_level [int unsigned];
    t_pixel_result     expected_pixels [$];
    int                error_count = 0;
    int                result_count = 0;

    assign o_errors  = error_count;
    assign o_checked = result_count;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    // Round down to the four camera channels, then clamp
    function automatic int unsigned eff_width();
        int unsigned v;
        v = cfg_width;
        v = v - (v % 4);
        if (v < 4) v = 4;
        if (v > WIDTH_CAP) v = WIDTH_CAP;
        return v;
    endfunction

    function automatic int unsigned eff_height();
        int unsigned v;
        v = cfg_height;
        if (v < 1) v = 1;
        if (v > HEIGHT_CAP) v = HEIGHT_CAP;
        return v;
    endfunction

    // Output column block for a lane (col mod 4)
    function automatic int unsigned lane_slot(input bit odd, input int unsigned lane);
        int unsigned k;
        if (odd) begin
            case (lane)
                0: k = 1;
                1: k = 0;
                2: k = 2;
                default: k = 3;
            endcase
        end else begin
            case (lane)
                0: k = 2;
                1: k = 3;
                2: k = 1;
                default: k = 0;
            endcase
        end
        return k;
    endfunction

    // Store a reset level or queue the corrected, remapped data pixel
    task automatic predict_pixel(input logic [TDATA_W-1:0] word);
        logic [15:0]   pix;
        logic [1:0]    quad;
        logic [11:0]   frame;
        logic [15:0]   level;
        int unsigned   row, col, w, h, addr;
        t_pixel_result want;
        pix   = word[15:0];
        quad  = word[17:16];
        frame = word[29:18];
        row   = word[38:30];
        col   = word[49:39];
        w     = eff_width();
        h     = eff_height();
        if (row >= h || col >= 2 * w) return;
        if (col >= w) begin
            reset_level[row * LINE_PITCH + col - w] = pix;
            return;
        end
        if (frame == '0) begin
            want.pix = pix;
        end else begin
            addr  = row * LINE_PITCH + col;
            level = reset_level.exists(addr) ? reset_level[addr] : 16'd0;
            want.pix = pix + BLACK_LIFT - level;
        end
        want.row   = IROW_W'(quad[0] ? h + (h - 1 - row) : row);
        want.col   = ICOL_W'((quad[1] ? w : 0) + col / 4
                             + lane_slot(quad[0], col % 4) * (w / 4));
        want.frame = frame;
        expected_pixels.push_back(want);
    endtask

    // Track registers, compare results, then predict the accepted item
    always @(posedge i_clk) begin
        t_pixel_result want;
        if (!i_rst_n) begin
            cfg_width  = DATA_WIDTH_RST;
            cfg_height = DATA_HEIGHT_RST;
            expected_pixels.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == REG_DATA_WIDTH) cfg_width = i_cfg_wdata;
                else cfg_height = i_cfg_wdata[CFGH_W-1:0];
            end
            if (i_out_valid && i_out_ready) begin
                result_count++;
                if (expected_pixels.size() == 0) begin
                    report_mismatch($sformatf("result %h with nothing expected",
                                              i_out_data));
                end else begin
                    want = expected_pixels.pop_front();
                    if (i_out_data[15:0] != want.pix)
                        report_mismatch($sformatf("out_pixel got %h want %h",
                                                  i_out_data[15:0], want.pix));
                    if (i_out_data[25:16] != want.row)
                        report_mismatch($sformatf("image_row got %0d want %0d",
                                                  i_out_data[25:16], want.row));
                    if (i_out_data[36:26] != want.col)
                        report_mismatch($sformatf("image_col got %0d want %0d",
                                                  i_out_data[36:26], want.col));
                    if (i_out_data[48:37] != want.frame)
                        report_mismatch($sformatf("out_frame got %0d want %0d",
                                                  i_out_data[48:37], want.frame));
                    if (i_out_data[TDATA_W-1:49] != '0)
                        report_mismatch($sformatf("fill bits got %h",
                                                  i_out_data[TDATA_W-1:49]));
                end
            end
            if (i_in_valid && i_in_ready) predict_pixel(i_in_data);
        end
        o_pending <= expected_pixels.size();
    end

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives the CDS pixel reassembly block with directed corner pixels and
// random raw rows under several register settings and stall patterns; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import cdspr_pkg::*;

    localparam int unsigned LINE_PITCH   = 1024;
    localparam int          DRAIN_CYCLES = 8;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    logic                i_clk     = 1'b0;
    logic                i_rst_n   = 1'b0;
    logic                cfg_we    = 1'b0;
    logic                cfg_addr  = REG_DATA_WIDTH;
    logic [CFGW_W-1:0]   cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic [TDATA_W-1:0]  s_tdata   = '0;
    logic                s_tready;
    logic                m_tvalid;
    logic                m_tready  = 1'b1;
    logic [TDATA_W-1:0]  m_tdata;

    int          sender_idle_pct = 0;
    int          recv_stall_pct  = 0;
    int unsigned cur_w = 1024;
    int unsigned cur_h = 512;
    bit          level_written [int unsigned];
    int          items_sent = 0;
    int          settings_used = 1;
    int          pending, errors, checked;

    cds_pixel_reassembly u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    cdspr_checker u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (s_tvalid),
        .i_in_ready  (s_tready),
        .i_in_data   (s_tdata),
        .i_out_valid (m_tvalid),
        .i_out_ready (m_tready),
        .i_out_data  (m_tdata),
        .o_pending   (pending),
        .o_errors    (errors),
        .o_checked   (checked)
    );

    // Clock, 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stall the result side at the current rate
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Guard against a hang
    initial begin
        #3_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic int unsigned clamp_width(input int unsigned raw);
        int unsigned v;
        v = raw - (raw % 4);
        if (v < 4) v = 4;
        if (v > 1024) v = 1024;
        return v;
    endfunction

    function automatic int unsigned clamp_height(input int unsigned raw);
        int unsigned v;
        v = raw;
        if (v < 1) v = 1;
        if (v > 512) v = 512;
        return v;
    endfunction

    task automatic select_idling(input t_idle_mode mode);
        case (mode)
            IDLE_NONE:   begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER: begin sender_idle_pct = 75; recv_stall_pct = 0;  end
            IDLE_RECV:   begin sender_idle_pct = 0;  recv_stall_pct = 75; end
            default:     begin sender_idle_pct = 34; recv_stall_pct = 34; end
        endcase
    endtask

    // Hold the input side until every result is out and the pipe is empty
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write both registers on back-to-back edges
    task automatic write_config(input int unsigned width, input int unsigned height);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_DATA_WIDTH;
        cfg_wdata <= width[CFGW_W-1:0];
        @(posedge i_clk);
        cfg_addr  <= REG_DATA_HEIGHT;
        cfg_wdata <= height[CFGW_W-1:0];
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        cur_w = clamp_width(width & 32'h7FF);
        cur_h = clamp_height(height & 32'h3FF);
        settings_used++;
    endtask

    // Offer one item; a data pixel of a later frame only reads a written level
    task automatic send_pixel(input logic [15:0] pix, input logic [1:0] quad,
                              input logic [11:0] frame, input int unsigned row,
                              input int unsigned col);
        bit active;
        active = (row < cur_h) && (col < 2 * cur_w);
        if (active && col < cur_w && frame != '0
            && !level_written.exists(row * LINE_PITCH + col))
            frame = '0;
        if (active && col >= cur_w) level_written[row * LINE_PITCH + col - cur_w] = 1'b1;
        if (active) items_sent++;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, col[10:0], row[8:0], frame, quad, pix};
        do @(posedge i_clk); while (!s_tready);
    endtask

    // Send a stretch of one raw row: data pixels, then their reset pixels
    task automatic row_burst();
        int unsigned lanes, c0, r, rows_hot;
        logic [1:0]  quad;
        logic [11:0] frame;
        lanes    = (cur_w <= 32) ? cur_w : 8;
        c0       = $urandom_range(0, 1) ? 0 : $urandom_range(0, cur_w - lanes);
        rows_hot = (cur_h < 4) ? cur_h : 4;
        r        = ($urandom_range(0, 3) == 0) ? $urandom_range(0, cur_h - 1)
                                              : $urandom_range(0, rows_hot - 1);
        quad     = 2'($urandom_range(0, 3));
        frame    = ($urandom_range(0, 3) == 0) ? 12'd0 : 12'($urandom_range(1, 4095));
        for (int i = 0; i < lanes; i++)
            send_pixel(16'($urandom), quad, frame, r, c0 + i);
        for (int i = 0; i < lanes; i++)
            send_pixel(16'($urandom), quad, frame, r, cur_w + c0 + i);
    endtask

    // Send one item with loose fields, often outside the frame
    task automatic noise_item();
        int unsigned r, c;
        r = $urandom_range(0, 1) ? $urandom_range(0, 511) : $urandom_range(0, cur_h - 1);
        c = $urandom_range(0, 1) ? $urandom_range(0, 2047) : $urandom_range(0, 2 * cur_w - 1);
        send_pixel(16'($urandom), 2'($urandom_range(0, 3)), 12'($urandom_range(0, 4095)),
                   r, c);
    endtask

    task automatic run_phase(input int unsigned width, input int unsigned height,
                             input t_idle_mode mode, input int count, input bit pause);
        int  start;
        bit  paused;
        write_config(width, height);
        select_idling(mode);
        start  = items_sent;
        paused = 1'b0;
        while (items_sent - start < count) begin
            if ($urandom_range(0, 99) < 70) row_burst();
            else noise_item();
            // Let the block run dry once in the middle of the phase
            if (pause && !paused && items_sent - start >= count / 2) begin
                wait_drained();
                paused = 1'b1;
            end
        end
    endtask

    // Stimulus and verdict
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Corner pixels at the reset register values
        select_idling(IDLE_NONE);
        send_pixel(16'hFFFF, 2'd0, 12'd0, 0, 0);
        send_pixel(16'h1234, 2'd0, 12'd0, 0, 1024);
        send_pixel(16'hFFFF, 2'd0, 12'd0, 0, 2047);
        // Reset level written by another quadrant
        send_pixel(16'h0000, 2'd1, 12'd1, 0, 0);
        send_pixel(16'h0000, 2'd2, 12'd4095, 0, 1023);
        send_pixel(16'hFFFF, 2'd3, 12'd0, 511, 1023);
        send_pixel(16'h0000, 2'd3, 12'd0, 511, 2047);
        send_pixel(16'hFFFF, 2'd3, 12'd1, 511, 1023);
        // Lanes 1 to 3 of every quadrant
        for (int q = 0; q < 4; q++)
            for (int lane = 1; lane < 4; lane++)
                send_pixel(16'($urandom), q[1:0], 12'd0, q, lane);

        // Smallest frame: row and column outside it are dropped
        write_config(0, 0);
        send_pixel(16'hA5A5, 2'd1, 12'd7, 1, 0);
        send_pixel(16'h5A5A, 2'd2, 12'd7, 0, 8);
        send_pixel(16'h0F0F, 2'd3, 12'd0, 0, 7);
        send_pixel(16'hF0F0, 2'd1, 12'd9, 0, 3);

        run_phase(0,    0,    IDLE_NONE,   60, 1'b0);
        run_phase(2047, 1023, IDLE_SENDER, 80, 1'b0);
        run_phase(13,   5,    IDLE_RECV,   80, 1'b1);
        run_phase(32,   3,    IDLE_BOTH,   80, 1'b0);
        run_phase(6,    2,    IDLE_NONE,   60, 1'b0);
        run_phase(1024, 512,  IDLE_BOTH,   80, 1'b1);
        run_phase(20,   7,    IDLE_SENDER, 80, 1'b0);
        run_phase(8,    2,    IDLE_RECV,   80, 1'b0);

        wait_drained();
        $display("Covered %0d pixel items and %0d results over %0d register settings,",
                 items_sent, checked, settings_used);
        $display("with sender gaps, receiver stalls and out-of-frame samples.");
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
